// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker in ontb_check.sv.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define ONTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check built on the plain form.
`define ONTB_ASSERT_IMP(lbl, ante, cons, msg) \
  `ONTB_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== design/ontb_pkg.sv =====
package ontb_pkg;

  localparam int unsigned ONTB_QF     = 14;
  localparam int unsigned ONTB_QW     = ONTB_QF + 1;
  localparam int unsigned ONTB_CMW    = 32;
  localparam int unsigned ONTB_NW     = 64;
  localparam int unsigned ONTB_CW     = 2 * ONTB_CMW + 2 * ONTB_QF + 2;
  localparam int unsigned ONTB_AW     = 98;
  localparam int unsigned ONTB_LANES  = 6;
  localparam int unsigned ONTB_QDEPTH = 2;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } ontb_in_t;

  typedef struct packed {
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_z;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] second_z;
    logic               degenerate;
  } ontb_out_t;

  // One classified item handed from the front end to the search pipeline.
  // Lanes 0..2 are the first tangent, lanes 3..5 the second.
  typedef struct packed {
    logic                                 degen;
    logic [ONTB_LANES-1:0]                neg;
    logic [ONTB_LANES-1:0][ONTB_CW-1:0]   csq;
    logic [ONTB_NW-1:0]                   n_first;
    logic [ONTB_NW-1:0]                   n_second;
  } ontb_job_t;

endpackage

// ===== design/ontb_front.sv =====
module ontb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ontb_pkg::ontb_in_t dir_i,
  input  logic              full_i,
  output logic              push_o,
  output ontb_pkg::ontb_job_t job_o
);
  import ontb_pkg::*;

  logic adv;
  assign adv = !full_i;

  // Stage 1: axis choice and first tangent.
  logic signed [16:0] ex, ey, ez;
  logic        [16:0] ax, ay, az;
  logic signed [16:0] t_d [3];
  logic               sel_x, sel_y;

  assign ex = $signed({dir_i.dir_x[15], dir_i.dir_x});
  assign ey = $signed({dir_i.dir_y[15], dir_i.dir_y});
  assign ez = $signed({dir_i.dir_z[15], dir_i.dir_z});
  assign ax = ex[16] ? 17'(-ex) : 17'(ex);
  assign ay = ey[16] ? 17'(-ey) : 17'(ey);
  assign az = ez[16] ? 17'(-ez) : 17'(ez);
  assign sel_x = (ax <= ay) && (ax <= az);
  assign sel_y = (ay <= ax) && (ay <= az);

  always_comb begin
    if (sel_x) begin
      t_d[0] = '0;  t_d[1] = -ez; t_d[2] = ey;
    end else if (sel_y) begin
      t_d[0] = ez;  t_d[1] = '0;  t_d[2] = -ex;
    end else begin
      t_d[0] = -ey; t_d[1] = ex;  t_d[2] = '0;
    end
  end

  logic               v1_q, dg1_q;
  logic signed [16:0] e1_q [3];
  logic signed [16:0] t1_q [3];

  // Stage 2: cross products and squares.
  logic               v2_q, dg2_q;
  logic signed [32:0] pp2_q [6];
  logic        [30:0] dsq2_q [3];
  logic        [30:0] tsq2_q [3];
  logic signed [16:0] t2_q [3];

  // Stage 3: differences, norms and magnitudes.
  logic               v3_q, dg3_q;
  logic [ONTB_LANES-1:0] neg3_q;
  logic [ONTB_CMW-1:0]   cmag3_q [ONTB_LANES];
  logic [31:0]           nd3_q, nt3_q;

  logic signed [33:0]    s_d [3];
  logic        [33:0]    smag_d [3];
  logic        [16:0]    tmag_d [3];

  always_comb begin
    s_d[0] = 34'(pp2_q[0]) - 34'(pp2_q[1]);
    s_d[1] = 34'(pp2_q[2]) - 34'(pp2_q[3]);
    s_d[2] = 34'(pp2_q[4]) - 34'(pp2_q[5]);
    for (int k = 0; k < 3; k++) begin
      smag_d[k] = s_d[k][33] ? 34'(-s_d[k]) : 34'(s_d[k]);
      tmag_d[k] = t2_q[k][16] ? 17'(-t2_q[k]) : 17'(t2_q[k]);
    end
  end

  // Stage 4: squared components and the product of norms.
  logic      v4_q;
  ontb_job_t job4_q;
  logic [2*ONTB_CMW-1:0] csq_d [ONTB_LANES];

  always_comb begin
    for (int l = 0; l < ONTB_LANES; l++) begin
      csq_d[l] = 64'(cmag3_q[l]) * 64'(cmag3_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dg1_q <= (dir_i.dir_x == '0) && (dir_i.dir_y == '0) && (dir_i.dir_z == '0);
      e1_q[0] <= ex;
      e1_q[1] <= ey;
      e1_q[2] <= ez;
      t1_q <= t_d;

      dg2_q    <= dg1_q;
      t2_q     <= t1_q;
      pp2_q[0] <= 33'(e1_q[1]) * 33'(t1_q[2]);
      pp2_q[1] <= 33'(e1_q[2]) * 33'(t1_q[1]);
      pp2_q[2] <= 33'(e1_q[2]) * 33'(t1_q[0]);
      pp2_q[3] <= 33'(e1_q[0]) * 33'(t1_q[2]);
      pp2_q[4] <= 33'(e1_q[0]) * 33'(t1_q[1]);
      pp2_q[5] <= 33'(e1_q[1]) * 33'(t1_q[0]);
      for (int k = 0; k < 3; k++) begin
        dsq2_q[k] <= 31'(e1_q[k]) * 31'(e1_q[k]);
        tsq2_q[k] <= 31'(t1_q[k]) * 31'(t1_q[k]);
      end

      dg3_q <= dg2_q;
      nd3_q <= 32'(dsq2_q[0]) + 32'(dsq2_q[1]) + 32'(dsq2_q[2]);
      nt3_q <= 32'(tsq2_q[0]) + 32'(tsq2_q[1]) + 32'(tsq2_q[2]);
      for (int k = 0; k < 3; k++) begin
        neg3_q[k]       <= t2_q[k][16];
        cmag3_q[k]      <= ONTB_CMW'(tmag_d[k]);
        neg3_q[3 + k]   <= s_d[k][33];
        cmag3_q[3 + k]  <= smag_d[k][ONTB_CMW-1:0];
      end

      job4_q.degen    <= dg3_q;
      job4_q.neg      <= neg3_q;
      job4_q.n_first  <= ONTB_NW'(nt3_q);
      job4_q.n_second <= 64'(nd3_q) * 64'(nt3_q);
      for (int l = 0; l < ONTB_LANES; l++) begin
        job4_q.csq[l] <= {csq_d[l], (2 * ONTB_QF + 2)'(0)};
      end
    end
  end

  assign push_o = v4_q && adv;
  assign job_o  = job4_q;

endmodule

// ===== design/ontb_queue.sv =====
module ontb_queue #(
  parameter int unsigned DEPTH = ontb_pkg::ONTB_QDEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ontb_pkg::ontb_job_t job_i,
  output logic                full_o,
  output logic                valid_o,
  output ontb_pkg::ontb_job_t job_o
);
  import ontb_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  ontb_job_t       mem [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CNTW-1:0] cnt_q;
  logic            pop;
  logic            valid_q;
  ontb_job_t       data_q;

  // The search pipeline never stalls, so an entry leaves as soon as one is held.
  assign pop    = (cnt_q != '0);
  assign full_o = (cnt_q == CNTW'(DEPTH));

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop) rd_q <= nxt(rd_q);
      if (push_i && !pop) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
      valid_q <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem[wr_q] <= job_i;
    if (pop) data_q <= mem[rd_q];
  end

  assign valid_o = valid_q;
  assign job_o   = data_q;

endmodule

// ===== design/ontb_back.sv =====
module ontb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  ontb_pkg::ontb_job_t job_i,
  output logic                res_valid_o,
  output ontb_pkg::ontb_out_t result_o
);
  import ontb_pkg::*;

  localparam int unsigned NST = ONTB_QW;

  typedef struct packed {
    logic [ONTB_QW-1:0]        q;
    logic signed [ONTB_AW-1:0] a;
    logic signed [ONTB_AW-1:0] b;
  } lane_t;

  logic      v_q   [NST];
  ontb_job_t job_q [NST];
  lane_t     ln_q  [NST][ONTB_LANES];

  // Each stage decides one bit of every lane's magnitude, MSB first. For the
  // odd value x = 2q-1 it keeps a = x*x*n and b = x*n, so trying a bit costs
  // only shifted adds and one compare against c*c*2^30.
  for (genvar k = 0; k < NST; k++) begin : g_stage
    localparam int unsigned BIT = NST - 1 - k;

    logic      vin;
    ontb_job_t jin;
    lane_t     lin  [ONTB_LANES];
    lane_t     lout [ONTB_LANES];

    if (k == 0) begin : g_init
      always_comb begin
        logic signed [ONTB_AW-1:0] n0;
        vin = valid_i;
        jin = job_i;
        for (int l = 0; l < ONTB_LANES; l++) begin
          n0 = $signed(ONTB_AW'(l < 3 ? job_i.n_first : job_i.n_second));
          lin[l].q = '0;
          lin[l].a = n0;
          lin[l].b = -n0;
        end
      end
    end else begin : g_link
      always_comb begin
        vin = v_q[k-1];
        jin = job_q[k-1];
        for (int l = 0; l < ONTB_LANES; l++) begin
          lin[l] = ln_q[k-1][l];
        end
      end
    end

    always_comb begin
      logic signed [ONTB_AW-1:0] nn, cand, cc;
      logic                      acc;
      for (int l = 0; l < ONTB_LANES; l++) begin
        nn   = $signed(ONTB_AW'(l < 3 ? jin.n_first : jin.n_second));
        cc   = $signed(ONTB_AW'(jin.csq[l]));
        cand = lin[l].a + (lin[l].b <<< (BIT + 2)) + (nn <<< (2 * BIT + 2));
        // Once the magnitude reaches 1.0 no lower bit may be added.
        acc  = (cand <= cc) && !lin[l].q[ONTB_QW-1];
        lout[l].q = acc ? (lin[l].q | (ONTB_QW'(1) << BIT)) : lin[l].q;
        lout[l].a = acc ? cand : lin[l].a;
        lout[l].b = acc ? (lin[l].b + (nn <<< (BIT + 1))) : lin[l].b;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      job_q[k] <= jin;
      for (int l = 0; l < ONTB_LANES; l++) begin
        ln_q[k][l] <= lout[l];
      end
    end
  end

  // Sign, degenerate masking and the output register.
  logic [15:0] comp [ONTB_LANES];
  logic        res_v_q;
  ontb_out_t   res_q;

  always_comb begin
    logic [15:0] mag;
    for (int l = 0; l < ONTB_LANES; l++) begin
      mag = 16'(ln_q[NST-1][l].q);
      if (job_q[NST-1].degen) begin
        comp[l] = '0;
      end else if (job_q[NST-1].neg[l]) begin
        comp[l] = 16'(-mag);
      end else begin
        comp[l] = mag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= v_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.first_x    <= $signed(comp[0]);
    res_q.first_y    <= $signed(comp[1]);
    res_q.first_z    <= $signed(comp[2]);
    res_q.second_x   <= $signed(comp[3]);
    res_q.second_y   <= $signed(comp[4]);
    res_q.second_z   <= $signed(comp[5]);
    res_q.degenerate <= job_q[NST-1].degen;
  end

  assign res_valid_o = res_v_q;
  assign result_o    = res_q;

endmodule

// ===== design/orthonormal_tangent_basis.sv =====
// Throughput: one item per cycle; the 15-stage bitwise magnitude search and the
// four front stages are fully pipelined, and busy rises only if the queue fills.
// Reset (rst_ni, asynchronous, active low) empties the pipeline and the queue;
// results cannot be held off, each is shown for exactly one cycle.
module orthonormal_tangent_basis #(
  parameter int unsigned QDEPTH = ontb_pkg::ONTB_QDEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  ontb_pkg::ontb_in_t  dir_i,
  output logic                busy,
  output logic                res_valid_o,
  output ontb_pkg::ontb_out_t result_o
);
  import ontb_pkg::*;

  // An item is taken whenever start is high and the queue has room.
  logic      accept;
  logic      q_full;
  logic      f_push;
  ontb_job_t f_job;
  logic      b_valid;
  ontb_job_t b_job;

  assign accept = start && !busy;
  assign busy   = q_full;

  // The front end picks the tangent axis, forms both cross products and
  // squares every component, so that each output lane needs only a compare.
  ontb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .dir_i   (dir_i),
    .full_i  (q_full),
    .push_o  (f_push),
    .job_o   (f_job)
  );

  // The queue decouples the front end from the search pipeline.
  ontb_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .job_i   (f_job),
    .full_o  (q_full),
    .valid_o (b_valid),
    .job_o   (b_job)
  );

  // The back end rounds each component of the unit vectors, one bit a stage.
  ontb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (b_valid),
    .job_i       (b_job),
    .res_valid_o (res_valid_o),
    .result_o    (result_o)
  );

endmodule

// ===== design/ontb_check.sv =====
`include "assert_macros.svh"

module ontb_check (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_i,
  input logic                res_valid_i,
  input ontb_pkg::ontb_out_t result_i
);
  import ontb_pkg::*;

  localparam int unsigned LAT = 22;

  logic acc;
  logic all_zero;
  logic first_nz;

  assign acc      = start_i && !busy_i;
  assign all_zero = (result_i.first_x == '0) && (result_i.first_y == '0) &&
                    (result_i.first_z == '0) && (result_i.second_x == '0) &&
                    (result_i.second_y == '0) && (result_i.second_z == '0);
  assign first_nz = (result_i.first_x != '0) || (result_i.first_y != '0) ||
                    (result_i.first_z != '0);

  `ONTB_ASSERT_IMP(a_no_spurious, res_valid_i, $past(acc, LAT), "result without item")
  `ONTB_ASSERT_IMP(a_no_loss, acc, ##LAT res_valid_i, "item lost")
  `ONTB_ASSERT_IMP(a_degen_zero, res_valid_i && result_i.degenerate, all_zero, "degenerate not zero")
  `ONTB_ASSERT_IMP(a_first_nonzero, res_valid_i && !result_i.degenerate, first_nz, "first zero")

endmodule

bind orthonormal_tangent_basis ontb_check u_ontb_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start),
  .busy_i      (busy),
  .res_valid_i (res_valid_o),
  .result_i    (result_o)
);

// ===== tb/orthonormal_tangent_basis_tb.sv =====
module orthonormal_tangent_basis_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ontb_pkg::*;

  // A short drain after the last expected result is enough to catch stray strobes.
  localparam int unsigned DrainCycles = 40;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  ontb_in_t  dir_i;
  logic      busy;
  logic      res_valid_o;
  ontb_out_t result_o;

  orthonormal_tangent_basis i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .dir_i      (dir_i),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .result_o   (result_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Tangents still owed by the block, oldest first.
  ontb_out_t pending_basis_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned idle_pct = 0;

  // Rounded Q2.14 magnitude of c / sqrt(na * nb), with the sign of c put back.
  // The largest q whose lower rounding boundary (q - 1/2) still lies at or
  // below the ideal value is the one rounded to nearest, halves away from
  // zero. The search settles one bit at a time from the top.
  function automatic logic [15:0] unit_component(longint c, longint unsigned na,
                                                 longint unsigned nb);
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [127:0] odd;
    longint unsigned mag;
    int unsigned q;
    int unsigned cand;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    rhs = (128'(mag) * 128'(mag)) << 30;
    q = 0;
    for (int b = 14; b >= 0; b--) begin
      cand = q | (1 << b);
      if (cand <= 16384) begin
        odd = 128'(2 * cand - 1);
        lhs = odd * odd * 128'(na) * 128'(nb);
        if (lhs <= rhs) q = cand;
      end
    end
    return (c < 0) ? 16'(-int'(q)) : 16'(q);
  endfunction

  // Expected basis for one direction. The smallest-magnitude axis is crossed
  // with the direction to give the first tangent; the second is the
  // direction crossed with the first.
  function automatic ontb_out_t tangent_basis(ontb_in_t d);
    ontb_out_t r;
    longint dx, dy, dz, ax, ay, az;
    longint t[3];
    longint s[3];
    longint unsigned nd, nt;
    dx = d.dir_x;
    dy = d.dir_y;
    dz = d.dir_z;
    r = '0;
    if (dx == 0 && dy == 0 && dz == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    az = (dz < 0) ? -dz : dz;
    // Ties favor x, then y.
    if (ax <= ay && ax <= az) begin
      t[0] = 0;   t[1] = -dz; t[2] = dy;
    end else if (ay <= ax && ay <= az) begin
      t[0] = dz;  t[1] = 0;   t[2] = -dx;
    end else begin
      t[0] = -dy; t[1] = dx;  t[2] = 0;
    end
    s[0] = dy * t[2] - dz * t[1];
    s[1] = dz * t[0] - dx * t[2];
    s[2] = dx * t[1] - dy * t[0];
    nd = dx * dx + dy * dy + dz * dz;
    nt = t[0] * t[0] + t[1] * t[1] + t[2] * t[2];
    // The two vectors are perpendicular, so the length of the second is the
    // product of the other two lengths.
    r.first_x  = unit_component(t[0], nt, 1);
    r.first_y  = unit_component(t[1], nt, 1);
    r.first_z  = unit_component(t[2], nt, 1);
    r.second_x = unit_component(s[0], nd, nt);
    r.second_y = unit_component(s[1], nd, nt);
    r.second_z = unit_component(s[2], nd, nt);
    r.degenerate = 1'b0;
    return r;
  endfunction

  // Results cannot be held off, so every strobe is checked at the edge that
  // ends its cycle against the oldest outstanding basis.
  always @(posedge clk_i) begin
    ontb_out_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_basis_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h", result_o);
      end else begin
        want = pending_basis_q.pop_front();
        if (result_o !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: first exp %0d %0d %0d got %0d %0d %0d",
                     want.first_x, want.first_y, want.first_z,
                     result_o.first_x, result_o.first_y, result_o.first_z);
            $display("  second exp %0d %0d %0d got %0d %0d %0d, degen exp %b got %b",
                     want.second_x, want.second_y, want.second_z,
                     result_o.second_x, result_o.second_y, result_o.second_z,
                     want.degenerate, result_o.degenerate);
          end
        end
      end
    end
  end

  // Offers one item and holds it until the block takes it. The expected
  // basis is queued at the accepting edge. Afterwards the line may go quiet
  // for a while; start is lowered only then, never just before raising it.
  task automatic offer_direction(ontb_in_t d, bit known, ontb_out_t known_basis);
    start <= 1'b1;
    dir_i <= d;
    do @(posedge clk_i); while (busy);
    pending_basis_q.push_back(known ? known_basis : tangent_basis(d));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      dir_i <= ontb_in_t'(48'({$urandom, $urandom}));
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [15:0] pick_component(int unsigned style);
    case (style)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 8)) - 16'sd4;
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom_range(0, 40000)) - 16'sd20000;
    endcase
  endfunction

  // Directed rows. Only the zero direction and the +x and +z directions carry a
  // typed-in answer; the rest go through the predictor.
  typedef struct {
    ontb_in_t  d;
    bit        known;
    ontb_out_t basis;
  } dir_row_t;

  dir_row_t directed_rows[$];

  initial begin
    ontb_in_t d;
    int unsigned style;
    directed_rows = '{
      // Zero direction: degenerate flag and all-zero vectors.
      '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, '{0, 0, 0, 0, 0, 0, 1'b1}},
      // Along +x: the y axis wins the tie with z.
      '{'{16'sd16384, 16'sd0, 16'sd0}, 1'b1,
        '{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 1'b0}},
      // Along +z: the x axis wins the tie with y.
      '{'{16'sd0, 16'sd0, 16'sd16384}, 1'b1,
        '{16'sd0, -16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b0}},
      '{'{16'sd0, 16'sd1, 16'sd0}, 1'b0, '0},
      '{'{16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0},
      '{'{16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, '0},
      '{'{16'sh8000, 16'sh7fff, 16'sh8000}, 1'b0, '0},
      '{'{16'sh7fff, 16'sh8000, 16'sd0}, 1'b0, '0},
      '{'{16'sd1, 16'sd1, 16'sd1}, 1'b0, '0},
      '{'{-16'sd1, 16'sd1, -16'sd1}, 1'b0, '0},
      '{'{16'sd5, -16'sd5, 16'sd9}, 1'b0, '0},
      '{'{16'sd9, 16'sd5, -16'sd5}, 1'b0, '0},
      '{'{16'sd3, 16'sd4, 16'sd0}, 1'b0, '0},
      '{'{16'sd0, 16'sh8000, 16'sd1}, 1'b0, '0},
      '{'{16'sd100, 16'sd200, 16'sd50}, 1'b0, '0},
      '{'{-16'sd16384, 16'sd1, 16'sd2}, 1'b0, '0},
      '{'{16'sd11585, 16'sd11585, 16'sd0}, 1'b0, '0},
      '{'{16'sh5555, 16'shaaaa, 16'sh1234}, 1'b0, '0}
    };
    start = 1'b0;
    dir_i = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      offer_direction(directed_rows[i].d, directed_rows[i].known, directed_rows[i].basis);

    // Random phases: back to back (twice), idle gaps after half the items, and after a third.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 50 : (phase == 3) ? 33 : 0;
      for (int n = 0; n < 210; n++) begin
        style = $urandom_range(0, 4);
        d.dir_x = pick_component(style);
        d.dir_y = pick_component(style);
        d.dir_z = pick_component(style);
        // Now and then force equal magnitudes to exercise the axis ties.
        if ($urandom_range(9) == 0) d.dir_y = $urandom_range(1) ? d.dir_x : -d.dir_x;
        if ($urandom_range(9) == 0) d.dir_z = d.dir_y;
        offer_direction(d, 1'b0, '0);
      end
    end
    start <= 1'b0;

    while (pending_basis_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_basis_q.size() == 0) begin
      $display("orthonormal_tangent_basis_tb passed");
    end else begin
      $display("orthonormal_tangent_basis_tb failed");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("orthonormal_tangent_basis_tb failed");
    $finish;
  end

endmodule
